### src/assert_macros.svh
// Assertion macros shared by the power-management register block.
// Included by the RTL files that check their own logic; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, off while reset is held
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, off while reset is held
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### src/apm_pkg.sv
// Shared types and constants for the ACPI PM1/GPE register block.
// No dependencies; used by every module of the block.
package apm_pkg;

  localparam int unsigned FUNC_W      = 2;
  localparam int unsigned ADDR_W      = 4;
  localparam int unsigned DATA_W      = 16;
  localparam int unsigned BYTE_W      = 8;
  localparam int unsigned GPE_IDX_W   = 5;
  localparam int unsigned GPE_SEL_W   = 2;
  localparam int unsigned GPE_BIT_W   = 3;
  localparam int unsigned SLP_TYP_W   = 3;
  localparam int unsigned CFG_IDX_W   = 1;
  localparam int unsigned GPE_BYTES_DEF = 4;

  // PM1 control bit positions
  localparam int unsigned SCI_EN_POS  = 0;
  localparam int unsigned SLP_TYP_LO  = 10;
  localparam int unsigned SLP_EN_POS  = 13;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_READ      = 2'd0,
    FUNC_WRITE     = 2'd1,
    FUNC_FIXED_EVT = 2'd2,
    FUNC_GPE_EVT   = 2'd3
  } func_t;

  // Register map
  localparam logic [ADDR_W-1:0] ADDR_PM1_STS    = 4'd0;
  localparam logic [ADDR_W-1:0] ADDR_PM1_EN     = 4'd1;
  localparam logic [ADDR_W-1:0] ADDR_PM1_CNT    = 4'd2;
  localparam logic [ADDR_W-1:0] ADDR_SMI_CMD    = 4'd3;
  localparam logic [ADDR_W-1:0] ADDR_RESET      = 4'd4;
  localparam logic [ADDR_W-1:0] ADDR_GPE_STS_LO = 4'd8;
  localparam logic [ADDR_W-1:0] ADDR_GPE_STS_HI = 4'd11;
  localparam logic [ADDR_W-1:0] ADDR_GPE_EN_LO  = 4'd12;
  localparam logic [ADDR_W-1:0] ADDR_GPE_EN_HI  = 4'd15;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ACPI_ENABLE   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_RESET_TRIGGER = 1'b1;

  typedef struct packed {
    func_t                func;
    logic [ADDR_W-1:0]    addr;
    logic [DATA_W-1:0]    wdata;
    logic [GPE_IDX_W-1:0] gpe_index;
  } in_req_t;

  typedef struct packed {
    logic [DATA_W-1:0]    rdata;
    logic                 sci_level;
    logic                 sleep_request;
    logic [SLP_TYP_W-1:0] sleep_type;
    logic                 reset_request;
  } out_rsp_t;

  // Byte-select code of GPE byte g
  function automatic logic [GPE_SEL_W-1:0] gpe_sel(input int unsigned g);
    return GPE_SEL_W'(g);
  endfunction

endpackage

### src/apm_in_reg.sv
// Input register of the PM1/GPE register block: holds one request for the core.
// Depends on apm_pkg for the request struct.
module apm_in_reg (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  apm_pkg::in_req_t in_data,
  input  logic             take,
  output logic             req_vld,
  output apm_pkg::in_req_t req_data
);

  logic             vld_r, vld_nxt;
  apm_pkg::in_req_t data_r;

  // Accept when empty or when the held request leaves this cycle
  assign in_ready = !vld_r || take;
  assign vld_nxt  = (vld_r && !take) || in_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (in_ready) begin
      vld_r <= in_valid;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  // Load a new request; payload needs no reset
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      data_r <= in_data;
    end
  end

  assign req_vld  = vld_r;
  assign req_data = data_r;

endmodule

### src/apm_core.sv
// PM1 status/enable/control, SMI_CMD, reset and GPE registers with SCI level.
// Depends on apm_pkg and assert_macros.svh.
`include "assert_macros.svh"

module apm_core #(
  parameter int unsigned GPE_BYTES = apm_pkg::GPE_BYTES_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [apm_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [apm_pkg::BYTE_W-1:0]       cfg_wdata,
  input  logic                             fire,
  input  apm_pkg::in_req_t                 req,
  output apm_pkg::out_rsp_t                rsp
);

  // Configuration
  logic [apm_pkg::BYTE_W-1:0]    acpi_en_val_r;
  logic [apm_pkg::BYTE_W-1:0]    rst_trig_val_r;

  // Architectural state
  logic [apm_pkg::DATA_W-1:0]    pm1_sts_r, pm1_sts_nxt;
  logic [apm_pkg::DATA_W-1:0]    pm1_en_r, pm1_en_nxt;
  logic                          sci_en_r, sci_en_nxt;
  logic [apm_pkg::SLP_TYP_W-1:0] slp_typ_r, slp_typ_nxt;
  logic [apm_pkg::BYTE_W-1:0]    gsts_r [GPE_BYTES];
  logic [apm_pkg::BYTE_W-1:0]    gsts_nxt [GPE_BYTES];
  logic [apm_pkg::BYTE_W-1:0]    gen_r [GPE_BYTES];
  logic [apm_pkg::BYTE_W-1:0]    gen_nxt [GPE_BYTES];
  logic [GPE_BYTES-1:0]          gpe_pend;

  // Decoded request
  logic                          is_wr, is_rd;
  logic                          addr_gsts, addr_gen;
  logic [apm_pkg::BYTE_W-1:0]    wbyte;
  logic [apm_pkg::BYTE_W-1:0]    evt_bit;
  logic [apm_pkg::BYTE_W-1:0]    gsts_rd, gen_rd;
  logic                          sleep_req, reset_req;
  logic [apm_pkg::DATA_W-1:0]    rdata;

  assign is_wr     = (req.func == apm_pkg::FUNC_WRITE);
  assign is_rd     = (req.func == apm_pkg::FUNC_READ);
  assign addr_gsts = (req.addr >= apm_pkg::ADDR_GPE_STS_LO) &&
                     (req.addr <= apm_pkg::ADDR_GPE_STS_HI);
  assign addr_gen  = (req.addr >= apm_pkg::ADDR_GPE_EN_LO);
  assign wbyte     = req.wdata[apm_pkg::BYTE_W-1:0];
  assign evt_bit   = apm_pkg::BYTE_W'(1) << req.gpe_index[apm_pkg::GPE_BIT_W-1:0];

  // Capture configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acpi_en_val_r  <= '0;
      rst_trig_val_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        apm_pkg::CFG_ACPI_ENABLE:   acpi_en_val_r  <= cfg_wdata;
        apm_pkg::CFG_RESET_TRIGGER: rst_trig_val_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Update GPE bytes: write-one-to-clear status, event set, enable load
  for (genvar g = 0; g < GPE_BYTES; g++) begin : g_gpe
    logic sel_addr, sel_evt;
    assign sel_addr = (req.addr[apm_pkg::GPE_SEL_W-1:0] == apm_pkg::gpe_sel(g));
    assign sel_evt  = (req.gpe_index[apm_pkg::GPE_IDX_W-1:apm_pkg::GPE_BIT_W] ==
                       apm_pkg::gpe_sel(g));

    always_comb begin
      gsts_nxt[g] = gsts_r[g];
      gen_nxt[g]  = gen_r[g];
      if (is_wr && addr_gsts && sel_addr) begin
        gsts_nxt[g] = gsts_r[g] & ~wbyte;
      end else if (req.func == apm_pkg::FUNC_GPE_EVT && sel_evt) begin
        gsts_nxt[g] = gsts_r[g] | evt_bit;
      end
      if (is_wr && addr_gen && sel_addr) begin
        gen_nxt[g] = wbyte;
      end
    end

    assign gpe_pend[g] = |(gsts_nxt[g] & gen_nxt[g]);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        gsts_r[g] <= '0;
        gen_r[g]  <= '0;
      end else if (fire) begin
        gsts_r[g] <= gsts_nxt[g];
        gen_r[g]  <= gen_nxt[g];
      end
    end
  end

  // Select the addressed GPE byte for reads; missing bytes read zero
  always_comb begin
    gsts_rd = '0;
    gen_rd  = '0;
    for (int unsigned g = 0; g < GPE_BYTES; g++) begin
      if (req.addr[apm_pkg::GPE_SEL_W-1:0] == apm_pkg::gpe_sel(g)) begin
        gsts_rd = gsts_r[g];
        gen_rd  = gen_r[g];
      end
    end
  end

  // PM1, SMI_CMD and reset register update
  always_comb begin
    pm1_sts_nxt = pm1_sts_r;
    pm1_en_nxt  = pm1_en_r;
    sci_en_nxt  = sci_en_r;
    slp_typ_nxt = slp_typ_r;
    sleep_req   = 1'b0;
    reset_req   = 1'b0;
    case (req.func)
      apm_pkg::FUNC_WRITE: begin
        case (req.addr)
          apm_pkg::ADDR_PM1_STS: pm1_sts_nxt = pm1_sts_r & ~req.wdata;
          apm_pkg::ADDR_PM1_EN:  pm1_en_nxt  = req.wdata;
          apm_pkg::ADDR_PM1_CNT: begin
            if (req.wdata[apm_pkg::SLP_EN_POS]) begin
              slp_typ_nxt = req.wdata[apm_pkg::SLP_TYP_LO +: apm_pkg::SLP_TYP_W];
              sleep_req   = 1'b1;
            end
          end
          apm_pkg::ADDR_SMI_CMD: begin
            if (wbyte == acpi_en_val_r) begin
              sci_en_nxt = 1'b1;
            end
          end
          apm_pkg::ADDR_RESET:   reset_req = (wbyte == rst_trig_val_r);
          default: ;
        endcase
      end
      apm_pkg::FUNC_FIXED_EVT: pm1_sts_nxt = pm1_sts_r | req.wdata;
      default: ;
    endcase
  end

  // Read mux, from state before this request
  always_comb begin
    rdata = '0;
    if (is_rd) begin
      case (req.addr) inside
        apm_pkg::ADDR_PM1_STS: rdata = pm1_sts_r;
        apm_pkg::ADDR_PM1_EN:  rdata = pm1_en_r;
        apm_pkg::ADDR_PM1_CNT: begin
          rdata[apm_pkg::SCI_EN_POS] = sci_en_r;
          rdata[apm_pkg::SLP_TYP_LO +: apm_pkg::SLP_TYP_W] = slp_typ_r;
        end
        [apm_pkg::ADDR_GPE_STS_LO:apm_pkg::ADDR_GPE_STS_HI]:
          rdata = apm_pkg::DATA_W'(gsts_rd);
        [apm_pkg::ADDR_GPE_EN_LO:apm_pkg::ADDR_GPE_EN_HI]:
          rdata = apm_pkg::DATA_W'(gen_rd);
        default: rdata = '0;
      endcase
    end
  end

  // Advance PM1 state on each processed request
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pm1_sts_r <= '0;
      pm1_en_r  <= '0;
      sci_en_r  <= 1'b0;
      slp_typ_r <= '0;
    end else if (fire) begin
      pm1_sts_r <= pm1_sts_nxt;
      pm1_en_r  <= pm1_en_nxt;
      sci_en_r  <= sci_en_nxt;
      slp_typ_r <= slp_typ_nxt;
    end
  end

  // Result: SCI level reflects state after this request
  always_comb begin
    rsp.rdata         = rdata;
    rsp.sci_level     = sci_en_nxt && ((|(pm1_sts_nxt & pm1_en_nxt)) || (|gpe_pend));
    rsp.sleep_request = sleep_req;
    rsp.sleep_type    = slp_typ_nxt;
    rsp.reset_request = reset_req;
  end

  `ASSERT_NEXT(a_sci_en_sticky, clk, rst_n, sci_en_r, sci_en_r, "SCI_EN cleared without reset")
  `ASSERT_NEXT(a_idle_hold, clk, rst_n, !fire, $stable(pm1_sts_r) && $stable(pm1_en_r), "PM1 state changed with no request")
  `ASSERT_IMPLIES(a_sci_needs_en, clk, rst_n, fire && rsp.sci_level, sci_en_nxt, "SCI raised outside ACPI mode")
  `ASSERT_NEXT(a_sleep_typ_rec, clk, rst_n, fire && sleep_req, slp_typ_r == $past(req.wdata[apm_pkg::SLP_TYP_LO +: apm_pkg::SLP_TYP_W]), "SLP_TYP not recorded")

endmodule

### src/acpi_power_event_register_block.sv
// Top level of the ACPI PM1 event/control and GPE register block.
// Depends on apm_pkg, apm_in_reg and apm_core.
//
//  channel  | handshake            | payload
//  ---------+----------------------+--------------------------------
//  in_      | in_valid / in_ready  | func, addr, wdata, gpe_index
//  out_     | out_valid / out_ready| rdata, sci_level, sleep_*, reset_request
//  cfg_     | cfg_we               | cfg_index, cfg_wdata
//
// One request per cycle while out_ready holds; requests pass input then result register.
// State updates and the result are formed combinationally between the two registers.
// Synchronous active-low reset clears all PM1/GPE state, configuration and valids.
// A stalled result holds in the output register while the input register still
// takes one more request; both stall only when the result is not taken.
module acpi_power_event_register_block #(
  parameter int unsigned GPE_BYTES = apm_pkg::GPE_BYTES_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  apm_pkg::in_req_t              in_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output apm_pkg::out_rsp_t             out_data,
  input  logic                          cfg_we,
  input  logic [apm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [apm_pkg::BYTE_W-1:0]    cfg_wdata
);

  logic              req_vld;
  apm_pkg::in_req_t  req_data;
  apm_pkg::out_rsp_t rsp;
  logic              out_free, fire;
  logic              out_valid_r;
  apm_pkg::out_rsp_t out_data_r;

  // Process a request when the result register can take it
  assign out_free = !out_valid_r || out_ready;
  assign fire     = req_vld && out_free;

  apm_in_reg u_in_reg (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .take     (fire),
    .req_vld  (req_vld),
    .req_data (req_data)
  );

  apm_core #(
    .GPE_BYTES (GPE_BYTES)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .fire      (fire),
    .req       (req_data),
    .rsp       (rsp)
  );

  // Result register valid: load on fire, drop when taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= fire;
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (fire) begin
      out_data_r <= rsp;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

### tb/tb_acpi_power_event_register_block.sv
// Self-checking testbench for the ACPI PM1/GPE register block: a directed table, then
// random register traffic, checked against a cycle-free model of the register state.
// Depends on apm_pkg and the acpi_power_event_register_block RTL.
module tb_acpi_power_event_register_block;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned RANDOM_PER_PHASE = 330;
  localparam int unsigned RX_HOLD_CYCLES   = 64;
  localparam int unsigned DRAIN_CYCLES     = 4;
  localparam int unsigned MAX_REPORTS      = 10;
  localparam longint unsigned RUN_LIMIT_NS = 2_000_000;

  typedef struct {
    apm_pkg::in_req_t  req;
    bit                typed;
    apm_pkg::out_rsp_t exp;
  } dir_row_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  apm_pkg::in_req_t  in_data = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  apm_pkg::out_rsp_t out_data;
  logic                          cfg_we = 1'b0;
  logic [apm_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [apm_pkg::BYTE_W-1:0]    cfg_wdata = '0;

  // Typed expectation that travels with the request on the bus
  bit                row_typed = 1'b0;
  apm_pkg::out_rsp_t row_rsp = '0;

  // Model state of the register block and its configuration
  logic [apm_pkg::DATA_W-1:0]    pm1_sts_m = '0;
  logic [apm_pkg::DATA_W-1:0]    pm1_en_m = '0;
  logic                          sci_en_m = 1'b0;
  logic [apm_pkg::SLP_TYP_W-1:0] slp_typ_m = '0;
  logic [apm_pkg::BYTE_W-1:0]    gpe_sts_m [apm_pkg::GPE_BYTES_DEF] = '{default: '0};
  logic [apm_pkg::BYTE_W-1:0]    gpe_en_m [apm_pkg::GPE_BYTES_DEF] = '{default: '0};
  logic [apm_pkg::BYTE_W-1:0]    acpi_en_val = '0;
  logic [apm_pkg::BYTE_W-1:0]    rst_trig_val = '0;

  apm_pkg::out_rsp_t awaited_rsp_q [$];
  int unsigned       fault_cnt = 0;

  // Stimulus control
  int unsigned                tx_idle_pct = 0;
  int unsigned                rx_idle_pct = 0;
  logic                       hold_req = 1'b0;
  logic                       hold_done = 1'b0;
  logic [apm_pkg::BYTE_W-1:0] smi_hit_byte = '0;
  logic [apm_pkg::BYTE_W-1:0] rst_hit_byte = '0;
  dir_row_t                   dir_rows [$];

  acpi_power_event_register_block dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Apply one request to the model state and return the response it produces
  function automatic apm_pkg::out_rsp_t predict_pm_access(input apm_pkg::in_req_t r);
    apm_pkg::out_rsp_t             rsp;
    logic [apm_pkg::BYTE_W-1:0]    wbyte;
    logic [apm_pkg::DATA_W-1:0]    pend;
    logic [apm_pkg::GPE_SEL_W-1:0] sel;
    rsp = '0;
    wbyte = r.wdata[apm_pkg::BYTE_W-1:0];
    case (r.func)
      apm_pkg::FUNC_READ: begin
        case (r.addr)
          apm_pkg::ADDR_PM1_STS: rsp.rdata = pm1_sts_m;
          apm_pkg::ADDR_PM1_EN:  rsp.rdata = pm1_en_m;
          apm_pkg::ADDR_PM1_CNT: begin
            rsp.rdata[apm_pkg::SCI_EN_POS] = sci_en_m;
            rsp.rdata[apm_pkg::SLP_TYP_LO +: apm_pkg::SLP_TYP_W] = slp_typ_m;
          end
          default: begin
            if (r.addr >= apm_pkg::ADDR_GPE_STS_LO && r.addr <= apm_pkg::ADDR_GPE_STS_HI) begin
              sel = apm_pkg::GPE_SEL_W'(r.addr - apm_pkg::ADDR_GPE_STS_LO);
              rsp.rdata = apm_pkg::DATA_W'(gpe_sts_m[sel]);
            end else if (r.addr >= apm_pkg::ADDR_GPE_EN_LO) begin
              sel = apm_pkg::GPE_SEL_W'(r.addr - apm_pkg::ADDR_GPE_EN_LO);
              rsp.rdata = apm_pkg::DATA_W'(gpe_en_m[sel]);
            end
          end
        endcase
      end
      apm_pkg::FUNC_WRITE: begin
        case (r.addr)
          apm_pkg::ADDR_PM1_STS: pm1_sts_m = pm1_sts_m & ~r.wdata;
          apm_pkg::ADDR_PM1_EN:  pm1_en_m = r.wdata;
          apm_pkg::ADDR_PM1_CNT: begin
            // Only SLP_EN matters; SCI_EN is owned by hardware
            if (r.wdata[apm_pkg::SLP_EN_POS]) begin
              slp_typ_m = r.wdata[apm_pkg::SLP_TYP_LO +: apm_pkg::SLP_TYP_W];
              rsp.sleep_request = 1'b1;
            end
          end
          apm_pkg::ADDR_SMI_CMD: if (wbyte == acpi_en_val) sci_en_m = 1'b1;
          apm_pkg::ADDR_RESET:   if (wbyte == rst_trig_val) rsp.reset_request = 1'b1;
          default: begin
            if (r.addr >= apm_pkg::ADDR_GPE_STS_LO && r.addr <= apm_pkg::ADDR_GPE_STS_HI) begin
              sel = apm_pkg::GPE_SEL_W'(r.addr - apm_pkg::ADDR_GPE_STS_LO);
              gpe_sts_m[sel] = gpe_sts_m[sel] & ~wbyte;
            end else if (r.addr >= apm_pkg::ADDR_GPE_EN_LO) begin
              sel = apm_pkg::GPE_SEL_W'(r.addr - apm_pkg::ADDR_GPE_EN_LO);
              gpe_en_m[sel] = wbyte;
            end
          end
        endcase
      end
      apm_pkg::FUNC_FIXED_EVT: pm1_sts_m = pm1_sts_m | r.wdata;
      default: begin
        sel = r.gpe_index[apm_pkg::GPE_IDX_W-1:apm_pkg::GPE_BIT_W];
        gpe_sts_m[sel][r.gpe_index[apm_pkg::GPE_BIT_W-1:0]] = 1'b1;
      end
    endcase
    // SCI level after the update
    pend = pm1_sts_m & pm1_en_m;
    for (int i = 0; i < apm_pkg::GPE_BYTES_DEF; i++)
      pend = pend | apm_pkg::DATA_W'(gpe_sts_m[i] & gpe_en_m[i]);
    rsp.sci_level = sci_en_m && (pend != '0);
    rsp.sleep_type = slp_typ_m;
    return rsp;
  endfunction

  function automatic apm_pkg::out_rsp_t rsp_of(input logic [apm_pkg::DATA_W-1:0] rd,
                                               input logic sci, input logic slp,
                                               input logic [apm_pkg::SLP_TYP_W-1:0] typ,
                                               input logic rst);
    apm_pkg::out_rsp_t r;
    r.rdata = rd;
    r.sci_level = sci;
    r.sleep_request = slp;
    r.sleep_type = typ;
    r.reset_request = rst;
    return r;
  endfunction

  function automatic dir_row_t mk_row(input apm_pkg::func_t f,
                                      input logic [apm_pkg::ADDR_W-1:0] a,
                                      input logic [apm_pkg::DATA_W-1:0] d,
                                      input logic [apm_pkg::GPE_IDX_W-1:0] g,
                                      input bit typed = 1'b0,
                                      input apm_pkg::out_rsp_t exp = '0);
    dir_row_t row;
    row.req.func = f;
    row.req.addr = a;
    row.req.wdata = d;
    row.req.gpe_index = g;
    row.typed = typed;
    row.exp = exp;
    return row;
  endfunction

  // Random register traffic, mostly to mapped addresses, with matching command bytes
  function automatic apm_pkg::in_req_t rand_req();
    apm_pkg::in_req_t r;
    int unsigned      pick;
    r.wdata = apm_pkg::DATA_W'($urandom);
    r.gpe_index = apm_pkg::GPE_IDX_W'($urandom_range(31));
    pick = $urandom_range(99);
    if (pick < 30) r.func = apm_pkg::FUNC_READ;
    else if (pick < 75) r.func = apm_pkg::FUNC_WRITE;
    else if (pick < 90) r.func = apm_pkg::FUNC_FIXED_EVT;
    else r.func = apm_pkg::FUNC_GPE_EVT;
    if ($urandom_range(99) < 15) begin
      r.addr = apm_pkg::ADDR_W'($urandom_range(15));
    end else begin
      pick = $urandom_range(12);
      r.addr = (pick < 5) ? apm_pkg::ADDR_W'(pick) :
                            apm_pkg::ADDR_W'(pick - 5 + apm_pkg::ADDR_GPE_STS_LO);
    end
    // Keep status masks sparse so bits come and go
    if (r.func == apm_pkg::FUNC_FIXED_EVT ||
        (r.func == apm_pkg::FUNC_WRITE && r.addr == apm_pkg::ADDR_PM1_STS))
      r.wdata = r.wdata & apm_pkg::DATA_W'($urandom);
    if (r.func == apm_pkg::FUNC_WRITE && $urandom_range(1) == 1) begin
      if (r.addr == apm_pkg::ADDR_SMI_CMD) r.wdata[apm_pkg::BYTE_W-1:0] = smi_hit_byte;
      if (r.addr == apm_pkg::ADDR_RESET) r.wdata[apm_pkg::BYTE_W-1:0] = rst_hit_byte;
      if (r.addr == apm_pkg::ADDR_PM1_CNT) r.wdata[apm_pkg::SLP_EN_POS] = 1'b1;
    end
    return r;
  endfunction

  // Offer one request, idling first at random; valid stays high after acceptance
  task automatic offer_req(input apm_pkg::in_req_t req, input bit typed,
                           input apm_pkg::out_rsp_t typed_rsp);
    if ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < tx_idle_pct);
    end
    in_valid <= 1'b1;
    in_data <= req;
    row_typed <= typed;
    row_rsp <= typed_rsp;
    do @(posedge clk); while (!in_ready);
  endtask

  // Drop valid and hold until every awaited response has come back
  task automatic wait_all_responses();
    in_valid <= 1'b0;
    @(posedge clk);
    while (awaited_rsp_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_pm_config(input logic [apm_pkg::BYTE_W-1:0] acpi,
                                 input logic [apm_pkg::BYTE_W-1:0] trig);
    wait_all_responses();
    smi_hit_byte = acpi;
    rst_hit_byte = trig;
    cfg_we <= 1'b1;
    cfg_index <= apm_pkg::CFG_ACPI_ENABLE;
    cfg_wdata <= acpi;
    @(posedge clk);
    cfg_index <= apm_pkg::CFG_RESET_TRIGGER;
    cfg_wdata <= trig;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic run_random(input int unsigned count);
    repeat (count) offer_req(rand_req(), 1'b0, '0);
  endtask

  // Stimulus
  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Directed table; configuration still at its reset values of zero
    dir_rows.push_back(mk_row(apm_pkg::FUNC_READ, apm_pkg::ADDR_PM1_STS, '0, '0, 1'b1,
                              rsp_of(16'h0000, 1'b0, 1'b0, 3'd0, 1'b0)));
    dir_rows.push_back(mk_row(apm_pkg::FUNC_READ, apm_pkg::ADDR_PM1_CNT, '0, '0, 1'b1,
                              rsp_of(16'h0000, 1'b0, 1'b0, 3'd0, 1'b0)));
    dir_rows.push_back(mk_row(apm_pkg::FUNC_READ, apm_pkg::ADDR_GPE_EN_HI, 16'hFFFF, 5'd31,
                              1'b1, rsp_of(16'h0000, 1'b0, 1'b0, 3'd0, 1'b0)));
    dir_rows.push_back(mk_row(apm_pkg::FUNC_READ, 4'd5, '0, '0, 1'b1,
                              rsp_of(16'h0000, 1'b0, 1'b0, 3'd0, 1'b0)));
    // Events and enables do not raise the SCI in legacy mode
    dir_rows.push_back(mk_row(apm_pkg::FUNC_FIXED_EVT, '0, 16'hFFFF, '0, 1'b1,
                              rsp_of(16'h0000, 1'b0, 1'b0, 3'd0, 1'b0)));
    dir_rows.push_back(mk_row(apm_pkg::FUNC_WRITE, apm_pkg::ADDR_PM1_EN, 16'hFFFF, '0, 1'b1,
                              rsp_of(16'h0000, 1'b0, 1'b0, 3'd0, 1'b0)));
    dir_rows.push_back(mk_row(apm_pkg::FUNC_READ, apm_pkg::ADDR_PM1_STS, '0, '0, 1'b1,
                              rsp_of(16'hFFFF, 1'b0, 1'b0, 3'd0, 1'b0)));
    // Zero enable byte matches a zero config value; upper byte ignored
    dir_rows.push_back(mk_row(apm_pkg::FUNC_WRITE, apm_pkg::ADDR_SMI_CMD, 16'hFF00, '0, 1'b1,
                              rsp_of(16'h0000, 1'b1, 1'b0, 3'd0, 1'b0)));
    dir_rows.push_back(mk_row(apm_pkg::FUNC_READ, apm_pkg::ADDR_PM1_CNT, '0, '0, 1'b1,
                              rsp_of(16'h0001, 1'b1, 1'b0, 3'd0, 1'b0)));
    dir_rows.push_back(mk_row(apm_pkg::FUNC_WRITE, apm_pkg::ADDR_PM1_STS, 16'hFFFF, '0, 1'b1,
                              rsp_of(16'h0000, 1'b0, 1'b0, 3'd0, 1'b0)));
    // Sleep request with all SLP_TYP bits, then a control write without SLP_EN
    dir_rows.push_back(mk_row(apm_pkg::FUNC_WRITE, apm_pkg::ADDR_PM1_CNT, 16'h3C01, '0, 1'b1,
                              rsp_of(16'h0000, 1'b0, 1'b1, 3'd7, 1'b0)));
    dir_rows.push_back(mk_row(apm_pkg::FUNC_WRITE, apm_pkg::ADDR_PM1_CNT, 16'hDFFE, '0, 1'b1,
                              rsp_of(16'h0000, 1'b0, 1'b0, 3'd7, 1'b0)));
    dir_rows.push_back(mk_row(apm_pkg::FUNC_READ, apm_pkg::ADDR_PM1_CNT, '0, '0, 1'b1,
                              rsp_of(16'h1C01, 1'b0, 1'b0, 3'd7, 1'b0)));
    dir_rows.push_back(mk_row(apm_pkg::FUNC_WRITE, apm_pkg::ADDR_RESET, 16'hAB00, '0, 1'b1,
                              rsp_of(16'h0000, 1'b0, 1'b0, 3'd7, 1'b1)));
    dir_rows.push_back(mk_row(apm_pkg::FUNC_WRITE, apm_pkg::ADDR_RESET, 16'h0001, '0));
    dir_rows.push_back(mk_row(apm_pkg::FUNC_READ, apm_pkg::ADDR_RESET, '0, '0));
    dir_rows.push_back(mk_row(apm_pkg::FUNC_GPE_EVT, '0, '0, 5'd31));
    dir_rows.push_back(mk_row(apm_pkg::FUNC_WRITE, apm_pkg::ADDR_GPE_EN_HI, 16'hFF80, '0));
    dir_rows.push_back(mk_row(apm_pkg::FUNC_READ, apm_pkg::ADDR_GPE_STS_HI, '0, '0));
    dir_rows.push_back(mk_row(apm_pkg::FUNC_GPE_EVT, '0, '0, 5'd0));
    dir_rows.push_back(mk_row(apm_pkg::FUNC_WRITE, apm_pkg::ADDR_GPE_STS_LO, 16'hFFFF, '0));
    dir_rows.push_back(mk_row(apm_pkg::FUNC_WRITE, 4'd6, 16'hFFFF, '0));
    dir_rows.push_back(mk_row(apm_pkg::FUNC_FIXED_EVT, '0, 16'h0100, '0));
    dir_rows.push_back(mk_row(apm_pkg::FUNC_WRITE, apm_pkg::ADDR_PM1_EN, '0, '0));
    dir_rows.push_back(mk_row(apm_pkg::FUNC_WRITE, apm_pkg::ADDR_GPE_EN_LO, 16'h00FF, '0));
    tx_idle_pct = 31;
    rx_idle_pct <= 57;
    foreach (dir_rows[i]) offer_req(dir_rows[i].req, dir_rows[i].typed, dir_rows[i].exp);

    // Receiver idles more than the sender
    write_pm_config(8'hFF, 8'hFF);
    run_random(RANDOM_PER_PHASE);

    // Sender idles more than the receiver
    write_pm_config(apm_pkg::BYTE_W'($urandom), 8'h00);
    tx_idle_pct = 57;
    rx_idle_pct <= 31;
    run_random(RANDOM_PER_PHASE);

    // No idling; first back up the block behind a long receiver hold-off
    write_pm_config(8'h00, apm_pkg::BYTE_W'($urandom));
    tx_idle_pct = 0;
    rx_idle_pct <= 0;
    hold_req <= 1'b1;
    while (!hold_done) offer_req(rand_req(), 1'b0, '0);
    run_random(RANDOM_PER_PHASE);

    wait_all_responses();
    if (awaited_rsp_q.size() != 0)
      $display("%0d responses never arrived", awaited_rsp_q.size());
    if (fault_cnt == 0 && awaited_rsp_q.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // Receiver: random stalls, plus one long hold-off on request
  initial begin : rx_side
    int unsigned n;
    forever begin
      @(posedge clk);
      if (hold_req && !hold_done) begin
        out_ready <= 1'b0;
        for (n = 0; n < RX_HOLD_CYCLES; n++) @(posedge clk);
        hold_done <= 1'b1;
      end
      out_ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // Track configuration, check responses, then record new requests
  always @(posedge clk) begin
    apm_pkg::out_rsp_t exp;
    if (rst_n) begin
      if (cfg_we) begin
        if (cfg_index == apm_pkg::CFG_ACPI_ENABLE) acpi_en_val = cfg_wdata;
        else if (cfg_index == apm_pkg::CFG_RESET_TRIGGER) rst_trig_val = cfg_wdata;
      end
      if (out_valid && out_ready) begin
        if (awaited_rsp_q.size() == 0) begin
          if (fault_cnt < MAX_REPORTS)
            $display("%0t: response with none awaited: rdata=%h sci=%b slp=%b typ=%0d rst=%b",
                     $time, out_data.rdata, out_data.sci_level, out_data.sleep_request,
                     out_data.sleep_type, out_data.reset_request);
          fault_cnt++;
        end else begin
          exp = awaited_rsp_q.pop_front();
          if (out_data !== exp) begin
            if (fault_cnt < MAX_REPORTS) begin
              $display("%0t: expected rdata=%h sci=%b slp=%b typ=%0d rst=%b", $time,
                       exp.rdata, exp.sci_level, exp.sleep_request, exp.sleep_type,
                       exp.reset_request);
              $display("%0t:      got rdata=%h sci=%b slp=%b typ=%0d rst=%b", $time,
                       out_data.rdata, out_data.sci_level, out_data.sleep_request,
                       out_data.sleep_type, out_data.reset_request);
            end
            fault_cnt++;
          end
        end
      end
      if (in_valid && in_ready) begin
        exp = predict_pm_access(in_data);
        awaited_rsp_q.push_back(row_typed ? row_rsp : exp);
      end
    end
  end

  // Stop a hung run
  initial begin
    #(RUN_LIMIT_NS);
    $display("Verification failed");
    $finish;
  end

endmodule

### files.f
+incdir+src
src/apm_pkg.sv
src/apm_in_reg.sv
src/apm_core.sv
src/acpi_power_event_register_block.sv
tb/tb_acpi_power_event_register_block.sv
